>>> rtl/jddm_pkg.sv
// ----------------------------------------------------------------------------
// jddm_pkg
// Shared constants for the joystick differential drive mixer.
// ----------------------------------------------------------------------------
package jddm_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int SENS_W = 17;
  localparam int DB_W = 15;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] REG_ARCADE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANA = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TSENS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RSENS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND = 3'd4;

  localparam logic [SENS_W-1:0] TSENS_RST = 17'd32768;
  localparam logic [SENS_W-1:0] RSENS_RST = 17'd45875;
  localparam logic [DB_W-1:0] DB_RST = 15'd3277;

endpackage

>>> rtl/joystick_differential_drive_mixer_core.sv
// ----------------------------------------------------------------------------
// joystick_differential_drive_mixer_core
// Arcade or tank stick mixer with deadband, cubic curve and normalization.
// ----------------------------------------------------------------------------
// One sample is taken at a time and runs a fixed sequence: deadband and cubic
// curve per axis, the arcade mix in arcade mode, then normalization. Every
// division runs on one restoring divider that produces one quotient bit per
// cycle; the divide by six of the rotation adjustment is a reciprocal multiply.
// An axis inside the deadband skips its divide, and a normalization divide
// runs only for a side beyond full scale. A result waits in the output
// register while the next sample is accepted; a second finished result holds
// until that register is read.
module joystick_differential_drive_mixer_core #(
  parameter int SAMPLE_WIDTH = jddm_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // thrust_stick, turn_stick, right_tank_stick
  input  logic [((3*SAMPLE_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // left_drive, right_drive
  output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] out_tdata,
  input  logic cfg_we,
  input  logic [jddm_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [jddm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  localparam int W = SAMPLE_WIDTH;
  localparam int F = W - 1;
  localparam int XW = W + 3;          // signed working width
  localparam int MW = 2 * XW;
  localparam int NW = 2 * W + 1;      // dividend width
  localparam int QCW = $clog2(NW + 1);
  localparam int OW = ((2*W+7)/8)*8;
  localparam int RS = XW + 3;
  localparam int P6W = 2 * XW + 4;
  localparam logic [P6W-1:0] RCP6 = P6W'(((64'd1 << RS) + 64'd5) / 64'd6);
  localparam logic signed [XW-1:0] ONE = XW'(1) <<< F;

  typedef enum logic [4:0] {
    S_IDLE, S_AX, S_DB, S_DBW, S_CU1, S_CU2, S_CU3, S_CU4, S_CU5,
    S_NEXT, S_MIX1, S_MIX2, S_N1, S_N1W, S_N2, S_N2W, S_OUT
  } state_t;

  state_t state_r;
  logic arcade_r, ana_r;
  logic [jddm_pkg::SENS_W-1:0] tsens_r, rsens_r;
  logic [jddm_pkg::DB_W-1:0] db_r;
  logic signed [W-1:0] t_in_r, r_in_r, k_in_r;
  logic [1:0] ax_r;                   // 0 thrust, 1 rotate
  logic signed [XW-1:0] t_r, r_r, prev_r, lft_r, rgt_r;
  logic [XW-1:0] u_r;
  logic neg_r;
  logic [MW-1:0] acc_r;
  // divider
  logic [NW-1:0] dq_r;
  logic [XW:0] drem_r;
  logic [XW-1:0] dden_r;
  logic [QCW-1:0] dcnt_r;
  logic dbusy_r;
  logic [OW-1:0] out_r;
  logic ov_r;

  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = ov_r;
  assign out_tdata = out_r;

  function automatic logic [XW-1:0] sat(input logic signed [XW-1:0] v);
    if (v > ONE - 1) return XW'(ONE - 1);
    if (v < -ONE) return XW'(-ONE);
    return v;
  endfunction

  logic [XW-1:0] dband;
  logic [XW:0] trial;
  logic signed [W-1:0] ax_val;
  logic [XW-1:0] ax_mag;
  logic [jddm_pkg::SENS_W-1:0] sens;
  logic [jddm_pkg::SENS_W-1:0] s_eff;
  logic [XW-1:0] r_mag, lft_mag, rgt_mag, div6_q;
  logic [P6W-1:0] prod6;
  logic [MW-1:0] bst_prod;
  logic signed [XW-1:0] bst;
  logic [XW-1:0] lft_sat, rgt_sat;
  always_comb begin
    if (F >= 15) dband = XW'(db_r) << (F - 15);
    else dband = XW'(db_r) >> (15 - F);
    trial = {drem_r[XW-1:0], dq_r[NW-1]} - {1'b0, dden_r};
    ax_val = (ax_r == 2'd0) ? t_in_r : (arcade_r ? r_in_r : k_in_r);
    ax_mag = ax_val[W-1] ? XW'(-$signed({{3{ax_val[W-1]}}, ax_val}))
                         : XW'({{3{1'b0}}, ax_val});
    sens = (ax_r == 2'd0) ? tsens_r : rsens_r;
    s_eff = sens[16] ? 17'd65536 : sens;
    r_mag = r_r[XW-1] ? XW'(-r_r) : XW'(r_r);
    lft_mag = lft_r[XW-1] ? XW'(-lft_r) : XW'(lft_r);
    rgt_mag = rgt_r[XW-1] ? XW'(-rgt_r) : XW'(rgt_r);
    prod6 = P6W'(acc_r[XW-1:0]) * RCP6;
    div6_q = XW'(prod6 >> RS);
    bst_prod = MW'(r_mag) * MW'(XW'(ONE) + acc_r[XW-1:0]);
    bst = r_r[XW-1] ? -$signed(XW'(bst_prod >> F)) : $signed(XW'(bst_prod >> F));
    lft_sat = sat(lft_r);
    rgt_sat = sat(rgt_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      arcade_r <= 1'b1;
      ana_r <= 1'b1;
      tsens_r <= jddm_pkg::TSENS_RST;
      rsens_r <= jddm_pkg::RSENS_RST;
      db_r <= jddm_pkg::DB_RST;
      prev_r <= '0;
      ov_r <= 1'b0;
      dbusy_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          jddm_pkg::REG_ARCADE: arcade_r <= cfg_wdata[0];
          jddm_pkg::REG_ANA: ana_r <= cfg_wdata[0];
          jddm_pkg::REG_TSENS: tsens_r <= cfg_wdata;
          jddm_pkg::REG_RSENS: rsens_r <= cfg_wdata;
          jddm_pkg::REG_DEADBAND: db_r <= cfg_wdata[jddm_pkg::DB_W-1:0];
          default: ;
        endcase
      end
      if (state_r == S_OUT && (!ov_r || out_tready)) ov_r <= 1'b1;
      else if (out_tready) ov_r <= 1'b0;
      if (dbusy_r) begin
        if (!trial[XW]) drem_r <= trial;
        else drem_r <= {drem_r[XW-1:0], dq_r[NW-1]};
        dq_r <= {dq_r[NW-2:0], ~trial[XW]};
        dcnt_r <= dcnt_r - 1'b1;
        if (dcnt_r == QCW'(1)) dbusy_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: if (in_tvalid && in_tready) begin
          t_in_r <= in_tdata[W-1:0];
          r_in_r <= in_tdata[2*W-1:W];
          k_in_r <= in_tdata[3*W-1:2*W];
          ax_r <= 2'd0;
          state_r <= S_AX;
        end
        S_AX: begin
          neg_r <= ax_val[W-1];
          if (ax_mag <= dband) begin
            u_r <= '0;
            state_r <= S_CU1;
          end else begin
            dq_r <= NW'(ax_mag - dband) << F;
            drem_r <= '0;
            dden_r <= XW'(ONE) - dband;
            dcnt_r <= QCW'(NW);
            dbusy_r <= 1'b1;
            state_r <= S_DB;
          end
        end
        S_DB: state_r <= S_DBW;
        S_DBW: if (!dbusy_r) begin
          u_r <= dq_r[XW-1:0];
          state_r <= S_CU1;
        end
        S_CU1: begin
          acc_r <= MW'(u_r) * MW'(u_r);
          state_r <= S_CU2;
        end
        S_CU2: begin
          acc_r <= MW'(acc_r >> F) * MW'(u_r);
          state_r <= S_CU3;
        end
        S_CU3: begin
          acc_r <= MW'(acc_r >> F) * MW'(s_eff);
          state_r <= S_CU4;
        end
        S_CU4: begin
          acc_r <= acc_r + MW'(u_r) * MW'(17'd65536 - s_eff);
          state_r <= S_CU5;
        end
        S_CU5: begin
          if (ax_r == 2'd0)
            t_r <= neg_r ? -$signed(XW'(acc_r >> 16)) : $signed(XW'(acc_r >> 16));
          else
            r_r <= neg_r ? -$signed(XW'(acc_r >> 16)) : $signed(XW'(acc_r >> 16));
          state_r <= S_NEXT;
        end
        S_NEXT: if (ax_r == 2'd0) begin
          ax_r <= 2'd1;
          state_r <= S_AX;
        end else if (arcade_r) begin
          // adjustment: |r-prev|*5/6
          acc_r <= MW'((r_r > prev_r) ? XW'(r_r - prev_r) : XW'(prev_r - r_r)) * MW'(5);
          state_r <= S_MIX1;
        end else begin
          lft_r <= t_r;
          rgt_r <= r_r;
          state_r <= S_N1;
        end
        S_MIX1: begin
          // divide by 6 through a reciprocal multiply
          acc_r <= MW'(div6_q);
          state_r <= S_MIX2;
        end
        S_MIX2: begin
          prev_r <= r_r;
          if (ana_r || !t_r[XW-1]) begin
            lft_r <= t_r + r_r;
            rgt_r <= t_r - bst;
          end else begin
            lft_r <= t_r - r_r;
            rgt_r <= t_r + bst;
          end
          state_r <= S_N1;
        end
        S_N1: begin
          if (lft_r > ONE || lft_r < -ONE) begin
            dq_r <= NW'(rgt_mag) << F;
            neg_r <= rgt_r[XW-1];
            drem_r <= '0;
            dden_r <= lft_mag;
            dcnt_r <= QCW'(NW);
            dbusy_r <= 1'b1;
            lft_r <= lft_r[XW-1] ? -ONE : ONE;
            state_r <= S_N1W;
          end else state_r <= S_N2;
        end
        S_N1W: if (!dbusy_r && dcnt_r == '0) begin
          rgt_r <= neg_r ? -$signed(dq_r[XW-1:0]) : $signed(dq_r[XW-1:0]);
          state_r <= S_N2;
        end
        S_N2: begin
          if (rgt_r > ONE || rgt_r < -ONE) begin
            dq_r <= NW'(lft_mag) << F;
            neg_r <= lft_r[XW-1];
            drem_r <= '0;
            dden_r <= rgt_mag;
            dcnt_r <= QCW'(NW);
            dbusy_r <= 1'b1;
            rgt_r <= rgt_r[XW-1] ? -ONE : ONE;
            state_r <= S_N2W;
          end else state_r <= S_OUT;
        end
        S_N2W: if (!dbusy_r && dcnt_r == '0) begin
          lft_r <= neg_r ? -$signed(dq_r[XW-1:0]) : $signed(dq_r[XW-1:0]);
          state_r <= S_OUT;
        end
        S_OUT: if (!ov_r || out_tready) begin
          out_r <= OW'({rgt_sat[W-1:0], lft_sat[W-1:0]});
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> state_r == S_IDLE) else $error("ready outside idle");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(out_tdata)) else $error("output changed");
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !dbusy_r) else $error("divider busy in idle");
endmodule
